/* sv/midpoint_ellipse_generator_defines.svh */
// Assertion macros for the midpoint ellipse generator RTL.
// No dependencies; the modules that check themselves include this file.
`ifndef MIDPOINT_ELLIPSE_GENERATOR_DEFINES_SVH
`define MIDPOINT_ELLIPSE_GENERATOR_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication, sampled on clk_i, off during reset
`define MPE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, sampled on clk_i, off during reset
`define MPE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MPE_ASSERT_IMP(lbl, ante, cons, msg)
`define MPE_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* sv/mpe_pkg.sv */
// Shared types and constants for the midpoint ellipse generator.
// No dependencies.
`timescale 1ns / 1ps

package mpe_pkg;

  localparam int unsigned COORD_W  = 13;
  localparam int unsigned CENTRE_W = 12;

  // command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_NEXT  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_A,
    ST_SQ_B,
    ST_AB,
    ST_INIT,
    ST_R2_M1,
    ST_R2_M2,
    ST_R2_M3,
    ST_R2_M4,
    ST_R2_M5,
    ST_R2_M6,
    ST_R2_FIN,
    ST_STEP,
    ST_DEC,
    ST_EMIT
  } seq_state_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQ_A,
    OP_SQ_B,
    OP_AB,
    OP_INIT,
    OP_R2_M1,
    OP_R2_M2,
    OP_R2_M3,
    OP_R2_M4,
    OP_R2_M5,
    OP_R2_M6,
    OP_R2_FIN,
    OP_STEP,
    OP_DEC,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   mul_en;
  } dp_ctrl_t;

  typedef struct packed {
    logic active;      // an ellipse is being traced
    logic step_ready;  // next step needs no region-2 setup
  } dp_stat_t;

endpackage

/* sv/mpe_mul.sv */
// Shared unsigned multiplier with registered product.
// No package dependencies.
`timescale 1ns / 1ps

module mpe_mul #(
  parameter int unsigned W = 22
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [W-1:0]     a_i,
  input  logic [W-1:0]     b_i,
  output logic [2*W-1:0]   prod_o
);

  logic [2*W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= (2*W)'(a_i) * (2*W)'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

/* sv/mpe_seq.sv */
// Sequencer: walks the setup, region-switch and step sequences.
// Depends on mpe_pkg and midpoint_ellipse_generator_defines.svh.
`timescale 1ns / 1ps
`include "midpoint_ellipse_generator_defines.svh"

module mpe_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              command_i,
  input  logic              out_free_i,
  input  mpe_pkg::dp_stat_t stat_i,
  output logic              in_ready_o,
  output mpe_pkg::dp_ctrl_t ctrl_o
);
  import mpe_pkg::*;

  seq_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          priority if (command_i == CMD_START) state_d = ST_SQ_A;
          else if (!stat_i.active)             state_d = ST_EMIT;
          else if (stat_i.step_ready)          state_d = ST_STEP;
          else                                 state_d = ST_R2_M1;
        end
      end
      ST_SQ_A:   state_d = ST_SQ_B;
      ST_SQ_B:   state_d = ST_AB;
      ST_AB:     state_d = ST_INIT;
      ST_INIT:   state_d = ST_EMIT;
      ST_R2_M1:  state_d = ST_R2_M2;
      ST_R2_M2:  state_d = ST_R2_M3;
      ST_R2_M3:  state_d = ST_R2_M4;
      ST_R2_M4:  state_d = ST_R2_M5;
      ST_R2_M5:  state_d = ST_R2_M6;
      ST_R2_M6:  state_d = ST_R2_FIN;
      ST_R2_FIN: state_d = ST_STEP;
      ST_STEP:   state_d = ST_DEC;
      ST_DEC:    state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o  = 1'b0;
    ctrl_o.op   = OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && command_i == CMD_START) ctrl_o.op = OP_LOAD;
      end
      ST_SQ_A:   ctrl_o.op = OP_SQ_A;
      ST_SQ_B:   ctrl_o.op = OP_SQ_B;
      ST_AB:     ctrl_o.op = OP_AB;
      ST_INIT:   ctrl_o.op = OP_INIT;
      ST_R2_M1:  ctrl_o.op = OP_R2_M1;
      ST_R2_M2:  ctrl_o.op = OP_R2_M2;
      ST_R2_M3:  ctrl_o.op = OP_R2_M3;
      ST_R2_M4:  ctrl_o.op = OP_R2_M4;
      ST_R2_M5:  ctrl_o.op = OP_R2_M5;
      ST_R2_M6:  ctrl_o.op = OP_R2_M6;
      ST_R2_FIN: ctrl_o.op = OP_R2_FIN;
      ST_STEP:   ctrl_o.op = OP_STEP;
      ST_DEC:    ctrl_o.op = OP_DEC;
      ST_EMIT: begin
        if (out_free_i) ctrl_o.op = OP_EMIT;
      end
      default:   ctrl_o.op = OP_NONE;
    endcase
    ctrl_o.mul_en = (ctrl_o.op == OP_SQ_A)  || (ctrl_o.op == OP_SQ_B)  ||
                    (ctrl_o.op == OP_AB)    || (ctrl_o.op == OP_R2_M1) ||
                    (ctrl_o.op == OP_R2_M2) || (ctrl_o.op == OP_R2_M3) ||
                    (ctrl_o.op == OP_R2_M4) || (ctrl_o.op == OP_R2_M5);
  end

  `MPE_ASSERT_IMP(a_step_active, state_q == ST_STEP, stat_i.active,
                  "step with no ellipse active")
  `MPE_ASSERT_IMP(a_step_ready, state_q == ST_STEP, stat_i.step_ready,
                  "step taken before region-2 setup finished")
  `MPE_ASSERT_IMP(a_emit_free, ctrl_o.op == OP_EMIT, out_free_i,
                  "result loaded while output register busy")

endmodule

/* sv/mpe_dp.sv */
// Datapath: ellipse state, step adders, region-2 accumulator and the shared
// multiplier. Depends on mpe_pkg and mpe_mul.
`timescale 1ns / 1ps

module mpe_dp #(
  parameter int unsigned AXIS_BITS = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mpe_pkg::dp_ctrl_t                 ctrl_i,
  input  logic [AXIS_BITS-1:0]              semi_axis_x_i,
  input  logic [AXIS_BITS-1:0]              semi_axis_y_i,
  input  logic signed [mpe_pkg::CENTRE_W-1:0] center_x_i,
  input  logic signed [mpe_pkg::CENTRE_W-1:0] center_y_i,
  output mpe_pkg::dp_stat_t                 stat_o,
  output logic signed [mpe_pkg::COORD_W-1:0] x_right_o,
  output logic signed [mpe_pkg::COORD_W-1:0] x_left_o,
  output logic signed [mpe_pkg::COORD_W-1:0] y_top_o,
  output logic signed [mpe_pkg::COORD_W-1:0] y_bottom_o,
  output logic                              last_o
);
  import mpe_pkg::*;

  localparam int unsigned XW  = AXIS_BITS + 1;      // x offset
  localparam int unsigned YW  = AXIS_BITS;          // y offset
  localparam int unsigned SQW = 2 * AXIS_BITS;      // squared axes
  localparam int unsigned SW  = 3 * AXIS_BITS + 3;  // step_dx / step_dy
  localparam int unsigned MW  = 2 * AXIS_BITS + 2;  // multiplier operand
  localparam int unsigned PW  = 2 * MW;             // product
  localparam int unsigned DW  = 4 * AXIS_BITS + 8;  // decision
  localparam int unsigned NW  = DW + 2;             // region-2 numerator
  localparam int unsigned CXW = COORD_W + XW;
  localparam int unsigned CYW = COORD_W + YW;

  logic [AXIS_BITS-1:0]       a_q, b_q;
  logic signed [CENTRE_W-1:0] cx_q, cy_q;
  logic [SQW-1:0]             asq_q, bsq_q;
  logic [XW-1:0]              x_q;
  logic [YW-1:0]              y_q;
  logic [SW-1:0]              dx_q, dy_q;
  logic signed [DW-1:0]       dec_q;
  logic signed [NW-1:0]       acc_q;
  logic                       take_q;
  logic                       active_q, r2_q;

  logic [MW-1:0]        mul_a, mul_b;
  logic [PW-1:0]        prod;
  logic [SW-1:0]        dbx, day;
  logic signed [DW-1:0] dec_inc;
  logic signed [NW-1:0] acc_adj;
  logic [CXW-1:0]       xr_sum, xl_sum;
  logic [CYW-1:0]       yt_sum, yb_sum;

  mpe_mul #(.W(MW)) u_mul (
    .clk_i  (clk_i),
    .en_i   (ctrl_i.mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl_i.op)
      OP_SQ_A: begin
        mul_a = MW'(a_q);
        mul_b = MW'(a_q);
      end
      OP_SQ_B: begin
        mul_a = MW'(b_q);
        mul_b = MW'(b_q);
      end
      OP_AB: begin
        mul_a = MW'(b_q);
        mul_b = MW'(asq_q);
      end
      OP_R2_M1: begin  // x*(x+1)
        mul_a = MW'(x_q);
        mul_b = MW'(x_q) + MW'(1);
      end
      OP_R2_M2: begin  // b^2 * x(x+1)
        mul_a = MW'(bsq_q);
        mul_b = prod[MW-1:0];
      end
      OP_R2_M3: begin  // (y-1)^2
        mul_a = MW'(y_q - YW'(1));
        mul_b = MW'(y_q - YW'(1));
      end
      OP_R2_M4: begin  // a^2 * (y-1)^2
        mul_a = MW'(asq_q);
        mul_b = prod[MW-1:0];
      end
      OP_R2_M5: begin  // a^2 * b^2
        mul_a = MW'(asq_q);
        mul_b = MW'(bsq_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign dbx = SW'({bsq_q, 1'b0});
  assign day = SW'({asq_q, 1'b0});

  // decision increment, uses the step values already updated by OP_STEP
  always_comb begin
    if (!r2_q) begin
      dec_inc = DW'(bsq_q) + DW'(dx_q) - (take_q ? DW'(dy_q) : DW'(0));
    end else begin
      dec_inc = DW'(asq_q) - DW'(dy_q) + (take_q ? DW'(dx_q) : DW'(0));
    end
  end

  // divide by 4 rounding toward zero: bias negatives by 3 before the shift
  assign acc_adj = acc_q + (acc_q[NW-1] ? NW'(3) : NW'(0));

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      OP_LOAD: begin
        a_q  <= semi_axis_x_i;
        b_q  <= semi_axis_y_i;
        cx_q <= center_x_i;
        cy_q <= center_y_i;
      end
      OP_SQ_B: asq_q <= prod[SQW-1:0];
      OP_AB:   bsq_q <= prod[SQW-1:0];
      OP_INIT: begin
        // prod = b*a^2
        dy_q  <= {prod[SW-2:0], 1'b0};
        dx_q  <= '0;
        x_q   <= '0;
        y_q   <= b_q;
        dec_q <= DW'(bsq_q) - DW'(prod) + DW'(asq_q >> 2);
      end
      OP_R2_M1: acc_q <= NW'(bsq_q);
      OP_R2_M3,
      OP_R2_M5: acc_q <= acc_q + NW'({prod, 2'b00});
      OP_R2_M6: acc_q <= acc_q - NW'({prod, 2'b00});
      OP_R2_FIN: dec_q <= acc_adj[NW-1:2];
      OP_STEP: begin
        if (!r2_q) begin
          x_q  <= x_q + XW'(1);
          dx_q <= dx_q + dbx;
          if (!dec_q[DW-1]) begin
            y_q    <= y_q - YW'(1);
            dy_q   <= dy_q - day;
            take_q <= 1'b1;
          end else begin
            take_q <= 1'b0;
          end
        end else begin
          y_q  <= y_q - YW'(1);
          dy_q <= dy_q - day;
          if (dec_q[DW-1] || dec_q == '0) begin
            x_q    <= x_q + XW'(1);
            dx_q   <= dx_q + dbx;
            take_q <= 1'b1;
          end else begin
            take_q <= 1'b0;
          end
        end
      end
      OP_DEC: dec_q <= dec_q + dec_inc;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      r2_q     <= 1'b0;
    end else begin
      unique case (ctrl_i.op)
        OP_INIT: begin
          active_q <= 1'b1;
          r2_q     <= 1'b0;
        end
        OP_R2_FIN: r2_q <= 1'b1;
        OP_EMIT: begin
          if (y_q == '0) active_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign stat_o.active     = active_q;
  assign stat_o.step_ready = r2_q || (dx_q < dy_q);

  // coordinates wrap to COORD_W bits
  assign xr_sum = CXW'(cx_q) + CXW'(x_q);
  assign xl_sum = CXW'(cx_q) - CXW'(x_q);
  assign yt_sum = CYW'(cy_q) + CYW'(y_q);
  assign yb_sum = CYW'(cy_q) - CYW'(y_q);

  assign x_right_o  = xr_sum[COORD_W-1:0];
  assign x_left_o   = xl_sum[COORD_W-1:0];
  assign y_top_o    = yt_sum[COORD_W-1:0];
  assign y_bottom_o = yb_sum[COORD_W-1:0];
  assign last_o     = (y_q == '0);

endmodule

/* sv/midpoint_ellipse_generator.sv */
// Midpoint ellipse generator, top level. Depends on mpe_pkg, mpe_seq, mpe_dp
// (with mpe_mul) and midpoint_ellipse_generator_defines.svh.
// Input channel (in_valid_i/in_ready_o): one item is a command plus the axes
// and centre. A start item loads a new ellipse and returns the top point; a
// next item returns the following point. Output channel (out_valid_o/
// out_ready_i): exactly one result item per input item, four mirrored pixel
// coordinates, last_o on the point with y offset 0, valid_res_o low for a
// next item when no ellipse is active (all other fields then zero).
// A start runs the squares, the b*a^2 product and ST_INIT; an ordinary step
// runs ST_STEP and ST_DEC; the step into region 2 runs the region-2 setup
// first; a next item when idle goes straight to ST_EMIT. Start and the
// region switch run their products one per cycle through the single shared
// multiplier (3 and 5 products); a step adds the offsets and step terms,
// then the decision value. Results go into the output register in ST_EMIT;
// one item is worked on at a time, but a new item is taken while a result
// still waits. When the receiver stalls, the finished result waits in the
// output register and the sequencer holds before loading the next one.
// Reset clears the sequencer and the active flag; no ellipse is active.
`timescale 1ns / 1ps
`include "midpoint_ellipse_generator_defines.svh"

module midpoint_ellipse_generator #(
  parameter int unsigned AXIS_BITS = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                command_i,
  input  logic [AXIS_BITS-1:0]                semi_axis_x_i,
  input  logic [AXIS_BITS-1:0]                semi_axis_y_i,
  input  logic signed [mpe_pkg::CENTRE_W-1:0] center_x_i,
  input  logic signed [mpe_pkg::CENTRE_W-1:0] center_y_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                valid_res_o,
  output logic signed [mpe_pkg::COORD_W-1:0]  x_right_o,
  output logic signed [mpe_pkg::COORD_W-1:0]  x_left_o,
  output logic signed [mpe_pkg::COORD_W-1:0]  y_top_o,
  output logic signed [mpe_pkg::COORD_W-1:0]  y_bottom_o,
  output logic                                last_o
);
  import mpe_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;
  logic     out_free;

  // current point straight from the datapath registers
  logic signed [COORD_W-1:0] pt_xr, pt_xl, pt_yt, pt_yb;
  logic                      pt_last;

  // output register
  logic                      out_valid_q;
  logic                      valid_res_q, last_q;
  logic signed [COORD_W-1:0] xr_q, xl_q, yt_q, yb_q;

  assign out_free = !out_valid_q || out_ready_i;

  mpe_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (command_i),
    .out_free_i (out_free),
    .stat_i     (stat),
    .in_ready_o (in_ready_o),
    .ctrl_o     (ctrl)
  );

  mpe_dp #(.AXIS_BITS(AXIS_BITS)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .semi_axis_x_i (semi_axis_x_i),
    .semi_axis_y_i (semi_axis_y_i),
    .center_x_i    (center_x_i),
    .center_y_i    (center_y_i),
    .stat_o        (stat),
    .x_right_o     (pt_xr),
    .x_left_o      (pt_xl),
    .y_top_o       (pt_yt),
    .y_bottom_o    (pt_yb),
    .last_o        (pt_last)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.op == OP_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // an idle next item reports an all-zero result
  always_ff @(posedge clk_i) begin
    if (ctrl.op == OP_EMIT) begin
      valid_res_q <= stat.active;
      xr_q        <= stat.active ? pt_xr : '0;
      xl_q        <= stat.active ? pt_xl : '0;
      yt_q        <= stat.active ? pt_yt : '0;
      yb_q        <= stat.active ? pt_yb : '0;
      last_q      <= stat.active && pt_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign valid_res_o = valid_res_q;
  assign x_right_o   = xr_q;
  assign x_left_o    = xl_q;
  assign y_top_o     = yt_q;
  assign y_bottom_o  = yb_q;
  assign last_o      = last_q;

  `MPE_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o,
                  "block ready again right after taking an item")
  `MPE_ASSERT_IMP(a_last_is_point, out_valid_o && last_o, valid_res_o,
                  "last flag on an empty result")
  `MPE_ASSERT_IMP(a_empty_is_zero, out_valid_o && !valid_res_o,
                  x_right_o == '0 && x_left_o == '0 && y_top_o == '0 && y_bottom_o == '0,
                  "empty result carries nonzero coordinates")

endmodule

/* dv/midpoint_ellipse_checker.sv */
// Scoreboard for the midpoint ellipse generator: predicts every result item from the
// accepted input items and compares it field by field. Depends on mpe_pkg.
`timescale 1ns / 1ps

module midpoint_ellipse_checker #(
  parameter int unsigned AXIS_BITS = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic                                command_i,
  input  logic [AXIS_BITS-1:0]                semi_axis_x_i,
  input  logic [AXIS_BITS-1:0]                semi_axis_y_i,
  input  logic signed [mpe_pkg::CENTRE_W-1:0] center_x_i,
  input  logic signed [mpe_pkg::CENTRE_W-1:0] center_y_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic                                valid_res_i,
  input  logic [mpe_pkg::COORD_W-1:0]         x_right_i,
  input  logic [mpe_pkg::COORD_W-1:0]         x_left_i,
  input  logic [mpe_pkg::COORD_W-1:0]         y_top_i,
  input  logic [mpe_pkg::COORD_W-1:0]         y_bottom_i,
  input  logic                                last_i,
  output int                                  fail_count_o,
  output int                                  pending_o
);
  import mpe_pkg::*;

  typedef struct {
    logic               valid_res;
    logic [COORD_W-1:0] x_right;
    logic [COORD_W-1:0] x_left;
    logic [COORD_W-1:0] y_top;
    logic [COORD_W-1:0] y_bottom;
    logic               last;
  } pixel_set_t;

  pixel_set_t expected_points[$];

  // tracer state, wide enough that nothing wraps before the coordinate sums
  bit     tr_active, tr_region2;
  longint ctr_x, ctr_y, a_sq, b_sq, off_x, off_y, slope_x, slope_y, dval;

  function automatic logic [COORD_W-1:0] wrap_coord(longint v);
    return v[COORD_W-1:0];
  endfunction

  // decision value at the switch into region 2, fixed-point form, truncated
  function automatic longint region2_entry();
    longint num;
    num = 4 * (b_sq * (off_x * off_x + off_x)) + b_sq
        + 4 * (a_sq * ((off_y - 1) * (off_y - 1))) - 4 * (a_sq * b_sq);
    return num / 4;
  endfunction

  task automatic trace_point(logic cmd, logic [AXIS_BITS-1:0] ax, logic [AXIS_BITS-1:0] ay,
                             logic signed [CENTRE_W-1:0] cx,
                             logic signed [CENTRE_W-1:0] cy);
    longint     a, b;
    pixel_set_t p;
    p = '{valid_res: 1'b0, x_right: '0, x_left: '0, y_top: '0, y_bottom: '0, last: 1'b0};
    if (cmd == CMD_START) begin
      a          = longint'(ax);
      b          = longint'(ay);
      ctr_x      = longint'(cx);
      ctr_y      = longint'(cy);
      a_sq       = a * a;
      b_sq       = b * b;
      dval       = b_sq - b * a_sq + a_sq / 4;
      slope_x    = 0;
      slope_y    = 2 * a_sq * b;
      off_x      = 0;
      off_y      = b;
      tr_region2 = 1'b0;
      tr_active  = 1'b1;
    end else if (!tr_active) begin
      expected_points.push_back(p);
      return;
    end else if (!tr_region2 && slope_x < slope_y) begin
      off_x++;
      slope_x += 2 * b_sq;
      if (dval >= 0) begin
        off_y--;
        slope_y -= 2 * a_sq;
        dval += b_sq + slope_x - slope_y;
      end else begin
        dval += b_sq + slope_x;
      end
    end else begin
      if (!tr_region2) begin
        dval       = region2_entry();
        tr_region2 = 1'b1;
      end
      off_y--;
      slope_y -= 2 * a_sq;
      if (dval <= 0) begin
        off_x++;
        slope_x += 2 * b_sq;
        dval += a_sq - slope_y + slope_x;
      end else begin
        dval += a_sq - slope_y;
      end
    end
    p.valid_res = 1'b1;
    p.x_right   = wrap_coord(ctr_x + off_x);
    p.x_left    = wrap_coord(ctr_x - off_x);
    p.y_top     = wrap_coord(ctr_y + off_y);
    p.y_bottom  = wrap_coord(ctr_y - off_y);
    p.last      = (off_y == 0);
    if (off_y == 0) tr_active = 1'b0;
    expected_points.push_back(p);
  endtask

  function automatic int field_bad(string field, logic [COORD_W-1:0] want,
                                   logic [COORD_W-1:0] got);
    if (got === want) return 0;
    $error("%s: expected %0d, actual %0d", field, $signed(want), $signed(got));
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_set_t want;
    int         bad;
    if (!rst_ni) begin
      expected_points.delete();
      tr_active    = 1'b0;
      tr_region2   = 1'b0;
      ctr_x        = 0;
      ctr_y        = 0;
      a_sq         = 0;
      b_sq         = 0;
      off_x        = 0;
      off_y        = 0;
      slope_x      = 0;
      slope_y      = 0;
      dval         = 0;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // an output taken at this edge always belongs to an older input item
      if (out_valid_i && out_ready_i) begin
        if (expected_points.size() == 0) begin
          $error("result item with no point pending");
          fail_count_o++;
        end else begin
          want = expected_points.pop_front();
          bad  = 0;
          bad += field_bad("valid_res", COORD_W'(want.valid_res), COORD_W'(valid_res_i));
          bad += field_bad("x_right", want.x_right, x_right_i);
          bad += field_bad("x_left", want.x_left, x_left_i);
          bad += field_bad("y_top", want.y_top, y_top_i);
          bad += field_bad("y_bottom", want.y_bottom, y_bottom_i);
          bad += field_bad("last", COORD_W'(want.last), COORD_W'(last_i));
          fail_count_o += bad;
        end
      end
      if (in_valid_i && in_ready_i)
        trace_point(command_i, semi_axis_x_i, semi_axis_y_i, center_x_i, center_y_i);
      pending_o = expected_points.size();
    end
  end

endmodule

/* dv/midpoint_ellipse_generator_tb.sv */
// Testbench top for the midpoint ellipse generator: clock, reset, stimulus and verdict.
// Depends on mpe_pkg, midpoint_ellipse_generator and midpoint_ellipse_checker.
`timescale 1ns / 1ps

module midpoint_ellipse_generator_tb;
  import mpe_pkg::*;

  localparam int unsigned AXIS_BITS = 10;
  localparam int          AXIS_MAX  = (1 << AXIS_BITS) - 1;
  localparam int          ITEM_GOAL = 800;
  // receiver hold-off: long enough that the block backs up and drops in_ready_o
  localparam int          HOLD_AT     = 300;
  localparam int          HOLD_CYCLES = 400;
  // stretch of items with no random idling on either side
  localparam int          CALM_FROM = 200;
  localparam int          CALM_TO   = 350;
  localparam int          IDLE_PCT  = 17;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic                        command_i;
  logic [AXIS_BITS-1:0]        semi_axis_x_i;
  logic [AXIS_BITS-1:0]        semi_axis_y_i;
  logic signed [CENTRE_W-1:0]  center_x_i;
  logic signed [CENTRE_W-1:0]  center_y_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic                        valid_res_o;
  logic signed [COORD_W-1:0]   x_right_o;
  logic signed [COORD_W-1:0]   x_left_o;
  logic signed [COORD_W-1:0]   y_top_o;
  logic signed [COORD_W-1:0]   y_bottom_o;
  logic                        last_o;

  int  mismatches;
  int  points_pending;
  int  items_sent;
  int  results_seen;
  int  lasts_seen;
  bit  held_off;

  midpoint_ellipse_generator #(
    .AXIS_BITS(AXIS_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .semi_axis_x_i(semi_axis_x_i),
    .semi_axis_y_i(semi_axis_y_i),
    .center_x_i   (center_x_i),
    .center_y_i   (center_y_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .valid_res_o  (valid_res_o),
    .x_right_o    (x_right_o),
    .x_left_o     (x_left_o),
    .y_top_o      (y_top_o),
    .y_bottom_o   (y_bottom_o),
    .last_o       (last_o)
  );

  midpoint_ellipse_checker #(
    .AXIS_BITS(AXIS_BITS)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .command_i    (command_i),
    .semi_axis_x_i(semi_axis_x_i),
    .semi_axis_y_i(semi_axis_y_i),
    .center_x_i   (center_x_i),
    .center_y_i   (center_y_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .valid_res_i  (valid_res_o),
    .x_right_i    (x_right_o),
    .x_left_i     (x_left_o),
    .y_top_i      (y_top_o),
    .y_bottom_i   (y_bottom_o),
    .last_i       (last_o),
    .fail_count_o (mismatches),
    .pending_o    (points_pending)
  );

  // 8 ns period
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Result-side bookkeeping. lasts_seen lets the sender tell when an ellipse
  // has been traced to its final point without predicting it itself.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen <= results_seen + 1;
      if (valid_res_o && last_o) lasts_seen <= lasts_seen + 1;
    end
  end

  function automatic bit calm_phase();
    return items_sent >= CALM_FROM && items_sent < CALM_TO;
  endfunction

  function automatic logic [CENTRE_W-1:0] rand_centre();
    logic [31:0] r;
    r = $urandom;
    return r[CENTRE_W-1:0];
  endfunction

  function automatic logic [AXIS_BITS-1:0] rand_axis(int lo, int hi);
    logic [31:0] r;
    r = $urandom_range(hi, lo);
    return r[AXIS_BITS-1:0];
  endfunction

  // Offer one item and hold it until taken. Called right after a falling
  // edge; valid stays high between back-to-back items and drops only for
  // an idle gap.
  task automatic send_item(logic cmd, logic [AXIS_BITS-1:0] ax, logic [AXIS_BITS-1:0] ay,
                           logic [CENTRE_W-1:0] cx, logic [CENTRE_W-1:0] cy);
    while (!calm_phase() && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    command_i     = cmd;
    semi_axis_x_i = ax;
    semi_axis_y_i = ay;
    center_x_i    = cy == cy ? cx : cx;
    center_y_i    = cy;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_start(int ax, int ay, logic [CENTRE_W-1:0] cx,
                            logic [CENTRE_W-1:0] cy);
    send_item(CMD_START, rand_axis(ax, ax), rand_axis(ay, ay), cx, cy);
  endtask

  // axis and centre fields are ignored on a next item, so they carry noise
  task automatic send_next();
    send_item(CMD_NEXT, rand_axis(0, AXIS_MAX), rand_axis(0, AXIS_MAX),
              rand_centre(), rand_centre());
  endtask

  // One random sequence: mostly a start followed by next items until the
  // final point comes back, with small axes so that whole ellipses, region
  // switch included, fit the item budget. Large axes are traced only a few
  // points and then abandoned by the following start. A few sequences are
  // stray next items only.
  task automatic random_sequence();
    int pick, cap, snap, n, a, b;
    pick = $urandom_range(99);
    if (pick < 6) begin
      n = $urandom_range(4, 1);
      repeat (n) send_next();
      return;
    end
    if (pick < 78) begin
      a = $urandom_range(12);
      b = $urandom_range(12);
    end else if (pick < 94) begin
      a = $urandom_range(60, 13);
      b = $urandom_range(60, 13);
    end else begin
      a = $urandom_range(AXIS_MAX);
      b = $urandom_range(AXIS_MAX);
    end
    if (pick >= 94 || $urandom_range(9) == 0) cap = $urandom_range(40, 1);
    else cap = 2 * (a + b) + 8;
    snap = lasts_seen;
    send_start(a, b, rand_centre(), rand_centre());
    n = 0;
    while (lasts_seen == snap && n < cap) begin
      send_next();
      n++;
    end
    // up to two next items past the end land on an idle block
    if (lasts_seen != snap) repeat ($urandom_range(2)) send_next();
  endtask

  // Receiver: random back-pressure, none in the calm stretch, and one long
  // hold-off while the sender keeps offering so the block fills up.
  initial begin
    out_ready_i = 1'b0;
    held_off    = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held_off && results_seen >= HOLD_AT) begin
        held_off    = 1'b1;
        out_ready_i = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      out_ready_i = calm_phase() || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Main stimulus and verdict.
  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    command_i     = CMD_NEXT;
    semi_axis_x_i = '0;
    semi_axis_y_i = '0;
    center_x_i    = '0;
    center_y_i    = '0;
    items_sent    = 0;
    results_seen  = 0;
    lasts_seen    = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // idle advance straight out of reset
    send_next();
    // zero axes: the start point is already the final one
    send_start(0, 0, 12'h000, 12'h000);
    send_next();
    // largest axes at the extreme centres, a few points, then a restart
    send_start(AXIS_MAX, AXIS_MAX, 12'h7FF, 12'h800);
    repeat (3) send_next();
    // restart with a = 0: goes to region 2 on the first step
    send_start(0, 5, 12'h800, 12'h7FF);
    repeat (6) send_next();
    // flat ellipse with b = 0 ends on its start point
    send_start(5, 0, 12'hFFF, 12'hFFF);
    // unit circle: one step to the end, then an idle advance
    send_start(1, 1, 12'h4D2, 12'hCF7);
    repeat (2) send_next();
    // very wide, very thin ellipse; abandoned by the first random start
    send_start(AXIS_MAX, 1, 12'h000, 12'h555);
    repeat (2) send_next();

    while (items_sent < ITEM_GOAL) random_sequence();
    in_valid_i = 1'b0;

    while (points_pending != 0) @(posedge clk_i);
    // let any stray late result show up before the verdict
    repeat (24) @(posedge clk_i);
    if (mismatches == 0 && points_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog timeout, far beyond the slowest legal run of this stimulus
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
